>>> rtl/ffc_pkg.sv
// shared types and constants for the float format converter
package ffc_pkg;

  localparam logic [1:0] OP_F32_TO_F16  = 2'd0;
  localparam logic [1:0] OP_F16_TO_F32  = 2'd1;
  localparam logic [1:0] OP_F32_TO_BF16 = 2'd2;
  localparam logic [1:0] OP_BF16_TO_F32 = 2'd3;

  localparam logic [15:0] H_INF  = 16'h7C00;
  localparam logic [15:0] H_QNAN = 16'h7E00;

  // pipeline control fields: valid bit and operation code
  typedef struct packed {
    logic       vld;
    logic [1:0] op;
  } ffc_ctl_t;

endpackage

>>> rtl/ffc_stage.sv
// one pipeline register stage with valid and stall propagation
module ffc_stage #(
  parameter int W = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [W-1:0]  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [W-1:0]  out_data
);
  logic         vld_r;
  logic [W-1:0] data_r;

  assign in_stall  = vld_r && out_stall;
  assign out_valid = vld_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (!in_stall) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      data_r <= in_data;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $past(vld_r && out_stall) |-> (vld_r && $stable(data_r)))
    else $error("stalled stage changed");
endmodule

>>> rtl/float_format_converter.sv
// top level: three-stage binary32/binary16/bfloat16 converter
//
//  channel | ports                            | direction
//  input   | in_valid in_stall in_operation in_operand | in
//  result  | out_valid out_stall out_converted | out
//
// one item per cycle sustained while the output is not stalled
// stage 1 decodes and aligns, stage 2 rounds and packs, stage 3 holds the result
// a stall at the output freezes all stages full; bubbles are absorbed
// reset clears only the stage valid bits
module float_format_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_operand,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_converted
);
  localparam logic [2:0] KIND_NAN    = 3'd0;
  localparam logic [2:0] KIND_INF    = 3'd1;
  localparam logic [2:0] KIND_NORM   = 3'd2;
  localparam logic [2:0] KIND_SUB    = 3'd3;
  localparam logic [2:0] KIND_ZERO   = 3'd4;
  localparam logic [2:0] KIND_DIRECT = 3'd5;

  // stage 1: decode
  logic        s1_sign;
  logic [7:0]  s1_e;
  logic [22:0] s1_m;
  logic [2:0]  s1_kind;
  logic [24:0] s1_mant;     // subnormal mantissa
  logic [4:0]  s1_shift;
  logic [31:0] s1_direct;
  logic [9:0]  hm;
  logic [4:0]  he;
  logic [3:0]  p;
  logic [9:0]  hsh;
  logic [7:0]  bshift;

  always_comb begin
    s1_sign = in_operand[31];
    s1_e = in_operand[30:23];
    s1_m = in_operand[22:0];
    s1_kind = KIND_DIRECT;
    s1_mant = '0;
    s1_shift = '0;
    s1_direct = '0;
    hm = in_operand[9:0];
    he = in_operand[14:10];
    p = 4'd0;
    for (int i = 0; i < 10; i++) if (hm[i]) p = 4'(i);
    hsh = hm << (4'd10 - p);
    bshift = 8'd126 - s1_e;
    case (in_operation)
      ffc_pkg::OP_F32_TO_F16: begin
        if (s1_e == 8'hFF) s1_kind = (s1_m != 0) ? KIND_NAN : KIND_INF;
        else if (s1_e >= 8'd143) s1_kind = KIND_INF;
        else if (s1_e >= 8'd113) s1_kind = KIND_NORM;
        else if (s1_e == 8'd0 || bshift >= 8'd25) s1_kind = KIND_ZERO;
        else begin
          s1_kind = KIND_SUB;
          s1_mant = {1'b0, 1'b1, s1_m};
          s1_shift = bshift[4:0];
        end
      end
      ffc_pkg::OP_F16_TO_F32: begin
        if (he == 5'h1F)
          s1_direct = (hm == 0) ? {in_operand[15], 31'h7F800000}
                    : {in_operand[15], 8'hFF, 1'b1, hm[8:0], 13'd0};
        else if (he != 0)
          s1_direct = {in_operand[15], 8'(he) + 8'd112, hm, 13'd0};
        else if (hm == 0)
          s1_direct = {in_operand[15], 31'd0};
        else
          s1_direct = {in_operand[15], 8'(p) + 8'd103, hsh[9:0], 13'd0};
      end
      ffc_pkg::OP_F32_TO_BF16: begin
        if (in_operand[30:0] > 31'h7F800000)
          s1_direct = {16'd0, in_operand[31:16] | 16'h0040};
        else if (s1_e == 0)
          s1_direct = {16'd0, s1_sign, 15'd0};
        else s1_kind = KIND_NORM;
      end
      default: s1_direct = {in_operand[15:0], 16'd0};
    endcase
  end

  logic [1:0]  op1;
  logic        sg1;
  logic [2:0]  k1;
  logic [7:0]  e1;
  logic [22:0] m1;
  logic [24:0] mt1;
  logic [4:0]  sh1;
  logic [31:0] d1;
  logic        v1, st1;

  ffc_stage #(.W(2+1+3+8+23+25+5+32)) u_s1 (
    .clk, .rst_n, .in_valid, .in_stall,
    .in_data({in_operation, s1_sign, s1_kind, s1_e, s1_m, s1_mant, s1_shift, s1_direct}),
    .out_valid(v1), .out_stall(st1),
    .out_data({op1, sg1, k1, e1, m1, mt1, sh1, d1}));

  // stage 2: round, or pass the direct result through
  logic [15:0] r2;
  logic [31:0] res2;
  logic [24:0] rem, half;
  logic [14:0] rn;
  logic [31:0] bsum;
  always_comb begin
    r2 = '0;
    rem = '0;
    half = '0;
    rn = '0;
    bsum = {sg1, e1, m1} + 32'h7FFF + {31'd0, m1[16]};
    res2 = d1;
    if (op1 == ffc_pkg::OP_F32_TO_F16) begin
      case (k1)
        KIND_NAN: r2 = ffc_pkg::H_QNAN;
        KIND_INF: r2 = ffc_pkg::H_INF;
        KIND_NORM: begin
          rn = {5'(e1 - 8'd112), m1[22:13]};
          if (m1[12:0] > 13'h1000 || (m1[12:0] == 13'h1000 && rn[0])) rn = rn + 15'd1;
          r2 = (rn >= 15'h7C00) ? ffc_pkg::H_INF : {1'b0, rn};
        end
        KIND_SUB: begin
          rn = 15'(mt1 >> sh1);
          rem = mt1 & ((25'd1 << sh1) - 25'd1);
          half = 25'd1 << (sh1 - 5'd1);
          if (rem > half || (rem == half && rn[0])) rn = rn + 15'd1;
          r2 = {1'b0, rn};
        end
        default: r2 = '0;
      endcase
      res2 = {16'd0, sg1 | r2[15], r2[14:0]};
    end else if (op1 == ffc_pkg::OP_F32_TO_BF16 && k1 == KIND_NORM) begin
      res2 = {16'd0, bsum[31:16]};
    end
  end

  logic [31:0] d2;
  logic        v2, st2;
  ffc_stage #(.W(32)) u_s2 (
    .clk, .rst_n, .in_valid(v1), .in_stall(st1), .in_data(res2),
    .out_valid(v2), .out_stall(st2), .out_data(d2));

  ffc_stage #(.W(32)) u_s3 (
    .clk, .rst_n, .in_valid(v2), .in_stall(st2), .in_data(d2),
    .out_valid, .out_stall, .out_data(out_converted));

  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !out_stall) ##1 !out_stall ##1 !out_stall |=> out_valid)
    else $error("item lost in pipeline");
  a_nostall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall) else $error("stall without full output");
  a_half: assert property (@(posedge clk) disable iff (!rst_n)
    (v1 && !st1 && (op1 == ffc_pkg::OP_F32_TO_F16 || op1 == ffc_pkg::OP_F32_TO_BF16)) |=>
    d2[31:16] == 16'd0) else $error("narrow result not zero-extended");
endmodule

>>> test/tb_float_format_converter.sv
// testbench for the float format converter: random and directed conversions checked in order
module tb_float_format_converter;

  class conversion_board;
    logic [31:0] pending_q[$];
    int errors;

    function logic [31:0] to_half(logic [31:0] x);
      logic [15:0] sign;
      logic [7:0] e;
      logic [22:0] m;
      logic [31:0] r, rem, mant, half;
      int shift;
      sign = {x[31], 15'd0};
      e = x[30:23];
      m = x[22:0];
      if (e == 8'hFF)
        return {16'd0, sign | ((m != 0) ? ffc_pkg::H_QNAN : ffc_pkg::H_INF)};
      if (e >= 143) return {16'd0, sign | ffc_pkg::H_INF};
      if (e >= 113) begin
        r = ((32'(e) - 112) << 10) + (m >> 13);
        rem = m & 32'h1FFF;
        if (rem > 32'h1000 || (rem == 32'h1000 && r[0])) r++;
        if (r >= 32'h7C00) r = 32'h7C00;
        return {16'd0, sign | r[15:0]};
      end
      if (e == 0) begin
        mant = m;
        shift = 125;
      end else begin
        mant = {9'd1, m};
        shift = 126 - e;
      end
      if (shift >= 25) return {16'd0, sign};
      r = mant >> shift;
      rem = mant & ((32'd1 << shift) - 1);
      half = 32'd1 << (shift - 1);
      if (rem > half || (rem == half && r[0])) r++;
      return {16'd0, sign | r[15:0]};
    endfunction

    function logic [31:0] from_half(logic [15:0] h);
      logic [31:0] sign;
      logic [4:0] e;
      logic [9:0] m;
      int p;
      sign = {h[15], 31'd0};
      e = h[14:10];
      m = h[9:0];
      if (e == 5'h1F) begin
        if (m == 0) return sign | 32'h7F800000;
        return sign | 32'h7FC00000 | (32'(m) << 13);
      end
      if (e != 0) return sign | ((32'(e) + 112) << 23) | (32'(m) << 13);
      if (m == 0) return sign;
      p = 9;
      while (!m[p]) p--;
      return sign | (32'(p + 103) << 23) | ((32'(m) << (23 - p)) & 32'h7FFFFF);
    endfunction

    function logic [31:0] to_brain(logic [31:0] x);
      logic [31:0] s;
      if ((x & 32'h7FFFFFFF) > 32'h7F800000) return {16'd0, x[31:16] | 16'h0040};
      if ((x & 32'h7F800000) == 0) return {16'd0, x[31], 15'd0};
      s = x + 32'h7FFF + 32'(x[16]);
      return {16'd0, s[31:16]};
    endfunction

    function void note_operand(logic [1:0] op, logic [31:0] v);
      logic [31:0] r;
      case (op)
        ffc_pkg::OP_F32_TO_F16: r = to_half(v);
        ffc_pkg::OP_F16_TO_F32: r = from_half(v[15:0]);
        ffc_pkg::OP_F32_TO_BF16: r = to_brain(v);
        default: r = {v[15:0], 16'd0};
      endcase
      pending_q.push_back(r);
    endfunction

    function void check_converted(logic [31:0] got);
      logic [31:0] want;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got !== want) begin
        $display("%0t: converted mismatch, expected %h, actual %h", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] in_operation = ffc_pkg::OP_F32_TO_F16;
  logic [31:0] in_operand = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [31:0] out_converted;

  conversion_board board = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_off = 0;
  int quiet_cycles = 0;

  float_format_converter dut (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) board.note_operand(in_operation, in_operand);
    if (rst_n && out_valid && !out_stall) board.check_converted(out_converted);
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 3000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_off) out_stall <= 1;
    else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic send_item(logic [1:0] op, logic [31:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_operation <= op;
    in_operand <= v;
    @(posedge clk iff !in_stall);
  endtask

  function automatic logic [31:0] random_operand(logic [1:0] op);
    logic [31:0] v;
    logic [7:0] e;
    v = $urandom;
    case ($urandom_range(5))
      0: e = 8'hFF;
      1: e = 8'h00;
      2: e = 8'($urandom_range(100, 145));
      3: e = 8'($urandom_range(112, 114));
      default: e = v[30:23];
    endcase
    if (op == ffc_pkg::OP_F32_TO_F16 || op == ffc_pkg::OP_F32_TO_BF16) v[30:23] = e;
    if ($urandom_range(3) == 0) v[12:0] = ($urandom_range(1)) ? 13'h1000 : 13'h0FFF;
    if (op == ffc_pkg::OP_F32_TO_BF16 && $urandom_range(3) == 0) v[15:0] = 16'h8000;
    if (op == ffc_pkg::OP_F16_TO_F32 || op == ffc_pkg::OP_BF16_TO_F32) begin
      if ($urandom_range(2) == 0) v[14:10] = ($urandom_range(1)) ? 5'h1F : 5'h00;
    end
    return v;
  endfunction

  task automatic drain();
    in_valid <= 0;
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  initial begin
    logic [31:0] directed[] = '{32'h0, 32'h80000000, 32'h7F800000, 32'hFF800000,
      32'h7FC00001, 32'hFF800001, 32'h477FEFFF, 32'h477FF000, 32'h33000000,
      32'h33000001, 32'h387FE000, 32'h00000001, 32'h7F7FFFFF, 32'h3F808000,
      32'h3F818000, 32'hFFFFFFFF, 32'h0000FC01, 32'h00000001, 32'h0000FFFF,
      32'h00007C00, 32'h000003FF, 32'h00008001};
    int phase;
    int i;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (directed[k]) send_item(2'(k % 4), directed[k]);
    for (i = 0; i < 4; i++) send_item(2'(i), 32'hFFFFFFFF);
    drain();
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 86 : 0;
      recv_idle_pct = (phase == 0) ? 86 : (phase == 1) ? 38 : 0;
      for (i = 0; i < 470; i++) begin
        logic [1:0] op;
        op = 2'($urandom_range(3));
        if (phase == 2 && i == 100) begin
          fork
            begin
              hold_off = 1;
              repeat (60) @(posedge clk);
              hold_off = 0;
            end
          join_none
        end
        send_item(op, random_operand(op));
      end
      drain();
    end
    if (board.errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule

>>> filelist.f
rtl/ffc_pkg.sv
rtl/ffc_stage.sv
rtl/float_format_converter.sv
test/tb_float_format_converter.sv
